// ===== rtl/vsi_pkg.sv =====
// ----------------------------------------------------------------------------
// vsi_pkg
// Shared types, constants and the exp table for the in-scattering integrator.
// ----------------------------------------------------------------------------
package vsi_pkg;

    localparam int EXP_TABLE_BITS = 10;
    localparam int EXP_TABLE_SIZE = (1 << EXP_TABLE_BITS) + 1;
    localparam int EXP_IDX_W      = EXP_TABLE_BITS + 1;

    localparam logic [32:0] LN2_Q32   = 33'd2977044472;
    localparam logic [20:0] LOG2E_Q20 = 21'd1512775;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;

    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 120;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_RED   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_GREEN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_BLUE  = 2'd2;

    typedef logic [32:0] exp_tab_t [EXP_TABLE_SIZE];

    typedef enum logic [2:0] {
        F_IDLE, F_MUL1, F_MUL2, F_TAB, F_INTERP, F_SHIFT, F_DIV, F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE, B_ACC
    } back_state_t;

    typedef struct packed {
        logic              first;
        logic [2:0][31:0]  src;
        logic [16:0]       t16;
        logic [31:0]       integral;
    } vsi_item_t;

    typedef struct packed {
        logic push;
        logic pop;
    } vsi_qctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } vsi_qstat_t;

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] y;
        logic [63:0] s;
        logic [63:0] term;
        for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
            y    = (64'(i) * 64'(LN2_Q32)) >> EXP_TABLE_BITS;
            s    = 64'(ONE_Q32);
            term = 64'(ONE_Q32);
            for (int n = 1; n <= 24; n++) begin
                term = ((term * y) >> 32) / 64'(n);
                if (n[0]) s = s - term;
                else s = s + term;
            end
            tab[i] = s[32:0];
        end
        return tab;
    endfunction

endpackage

// ===== rtl/volumetric_scatter_integrate_unit.sv =====
// ----------------------------------------------------------------------------
// volumetric_scatter_integrate_unit
// Front-to-back froxel column in-scattering integrator, fixed point.
//
//   channel | direction | contents
//   s_      | in        | one slice (tuser: first_in_column)
//   m_      | out       | radiance red/green/blue and transmittance
//   cfg_    | in        | light red/green/blue, write only
//
// Per slice the front goes through the accept state, five arithmetic
// stages, a bit-serial divider for the integral factor and a push state
// that waits while the queue is full; it takes no new slice before the
// push. Zero extinction skips the divider. The back pops each slice and
// then accumulates it. Reset is synchronous, active low, and clears
// accumulators to zero radiance and full transmittance. A stalled
// m_tready holds one result; the two-entry queue absorbs further slices.
// ----------------------------------------------------------------------------
module volumetric_scatter_integrate_unit import vsi_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // extinction, scatter_red, scatter_green, scatter_blue, emit_red,
    // emit_green, emit_blue, visibility, step_length, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // first_in_column
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // radiance_red, radiance_green, radiance_blue, transmittance, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [2:0][23:0] light_reg;
    logic [2:0][23:0] scatter;
    logic [2:0][23:0] emit;
    logic [2:0][31:0] radiance;
    logic [16:0]      trans;
    vsi_item_t        push_item;
    vsi_item_t        pop_item;
    vsi_qctl_t        qctl;
    vsi_qstat_t       qstat;
    logic             out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LIGHT_RED:   light_reg[0] <= cfg_wdata;
                REG_LIGHT_GREEN: light_reg[1] <= cfg_wdata;
                REG_LIGHT_BLUE:  light_reg[2] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign scatter = {s_tdata[95:72], s_tdata[71:48], s_tdata[47:24]};
    assign emit    = {s_tdata[167:144], s_tdata[143:120], s_tdata[119:96]};

    vsi_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .first_in_column (s_tuser),
        .extinction      (s_tdata[23:0]),
        .scatter         (scatter),
        .emit            (emit),
        .visibility      (s_tdata[184:168]),
        .step_length     (s_tdata[216:185]),
        .light           (light_reg),
        .qstat           (qstat),
        .q_push          (qctl.push),
        .q_item          (push_item)
    );

    vsi_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (qctl),
        .wr_item (push_item),
        .rd_item (pop_item),
        .stat    (qstat)
    );

    vsi_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_item       (pop_item),
        .qstat        (qstat),
        .q_pop        (qctl.pop),
        .out_valid    (out_valid),
        .out_ready    (m_tready),
        .out_radiance (radiance),
        .out_trans    (trans)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {7'd0, trans, radiance[2], radiance[1], radiance[0]};

endmodule

// ===== rtl/vsi_front.sv =====
// ----------------------------------------------------------------------------
// vsi_front
// Per-slice work: source terms, exp(-od) from the table, and the integral
// factor through a one-bit-per-cycle divider. Pushes one item to the queue.
// ----------------------------------------------------------------------------
module vsi_front import vsi_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             first_in_column,
    input  logic [23:0]      extinction,
    input  logic [2:0][23:0] scatter,
    input  logic [2:0][23:0] emit,
    input  logic [16:0]      visibility,
    input  logic [31:0]      step_length,
    input  logic [2:0][23:0] light,
    input  vsi_qstat_t       qstat,
    output logic             q_push,
    output vsi_item_t        q_item
);

    localparam exp_tab_t EXP_TAB = build_exp_tab();

    front_state_t state_reg, state_next;

    logic              first_reg;
    logic [23:0]       ext_reg;
    logic [31:0]       step_reg;
    logic [16:0]       vis_reg;
    logic [2:0][23:0]  scat_reg;
    logic [2:0][23:0]  emit_reg;
    logic [2:0][31:0]  p1_reg;
    logic [2:0][31:0]  src_reg;
    logic [55:0]       od_reg;
    logic              sat_reg;
    logic [56:0]       z_reg;
    logic [32:0]       a_reg;
    logic [32:0]       b_reg;
    logic [15:0]       r_reg;
    logic [4:0]        k_reg;
    logic [32:0]       diff_reg;
    logic [32:0]       tq_reg;
    logic [32:0]       num_reg;
    logic [23:0]       rem_reg;
    logic [5:0]        cnt_reg;
    logic              div_done;

    logic [EXP_IDX_W-1:0] idx;
    logic [32:0]          tq_comb;
    logic [24:0]          trial;
    logic                 qbit;
    logic [33:0]          t_round;

    assign idx      = {1'b0, z_reg[51 -: EXP_TABLE_BITS]};
    assign tq_comb  = sat_reg ? 33'd0 : ((a_reg - diff_reg) >> k_reg);
    assign trial    = {rem_reg, num_reg[32]};
    assign qbit     = (trial >= {1'b0, ext_reg});
    assign div_done = (cnt_reg == 6'd0);
    assign t_round  = {1'b0, tq_reg} + 34'd32768;
    assign in_ready = (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !qstat.full;

    always_comb begin
        q_item.first = first_reg;
        q_item.src   = src_reg;
        q_item.t16   = t_round[32:16];
        if (ext_reg == 24'd0) begin
            q_item.integral = step_reg;
        end else if (num_reg > {1'b0, step_reg}) begin
            q_item.integral = step_reg;
        end else begin
            q_item.integral = num_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:   if (in_valid) state_next = F_MUL1;
            F_MUL1:   state_next = F_MUL2;
            F_MUL2:   state_next = F_TAB;
            F_TAB:    state_next = F_INTERP;
            F_INTERP: state_next = F_SHIFT;
            F_SHIFT:  state_next = (ext_reg == 24'd0) ? F_PUSH : F_DIV;
            F_DIV:    if (div_done) state_next = F_PUSH;
            F_PUSH:   if (!qstat.full) state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                first_reg <= first_in_column;
                ext_reg   <= extinction;
                step_reg  <= step_length;
                vis_reg   <= (visibility > ONE_Q16) ? ONE_Q16 : visibility;
                scat_reg  <= scatter;
                emit_reg  <= emit;
            end
            F_MUL1: begin
                od_reg <= 56'(ext_reg) * 56'(step_reg);
                for (int c = 0; c < 3; c++) begin
                    p1_reg[c] <= 32'((48'(scat_reg[c]) * 48'(light[c])) >> 16);
                end
            end
            F_MUL2: begin
                sat_reg <= (od_reg[55:36] != 20'd0);
                z_reg   <= 57'(od_reg[35:0]) * 57'(LOG2E_Q20);
                for (int c = 0; c < 3; c++) begin
                    logic [33:0] s;
                    s = 34'((49'(p1_reg[c]) * 49'(vis_reg)) >> 16) + 34'(emit_reg[c]);
                    src_reg[c] <= (s > 34'(MAX32)) ? MAX32 : s[31:0];
                end
            end
            F_TAB: begin
                a_reg <= EXP_TAB[idx];
                b_reg <= EXP_TAB[idx + EXP_IDX_W'(1)];
                r_reg <= z_reg[51-EXP_TABLE_BITS -: 16];
                k_reg <= z_reg[56:52];
            end
            F_INTERP: begin
                diff_reg <= 33'(((49'(a_reg - b_reg)) * 49'(r_reg)) >> 16);
            end
            F_SHIFT: begin
                tq_reg  <= tq_comb;
                num_reg <= ONE_Q32 - tq_comb;
                rem_reg <= 24'd0;
                cnt_reg <= 6'd32;
            end
            F_DIV: begin
                rem_reg <= qbit ? 24'(trial - {1'b0, ext_reg}) : trial[23:0];
                num_reg <= {num_reg[31:0], qbit};
                cnt_reg <= cnt_reg - 6'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/vsi_fifo.sv =====
// ----------------------------------------------------------------------------
// vsi_fifo
// Two-entry queue between the per-slice front and the accumulating back.
// ----------------------------------------------------------------------------
module vsi_fifo import vsi_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  vsi_qctl_t  ctl,
    input  vsi_item_t  wr_item,
    output vsi_item_t  rd_item,
    output vsi_qstat_t stat
);

    vsi_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign do_push    = ctl.push && !stat.full;
    assign do_pop     = ctl.pop && !stat.empty;
    assign rd_item    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop) rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// ===== rtl/vsi_back.sv =====
// ----------------------------------------------------------------------------
// vsi_back
// Column accumulation: weights each source by transmittance and integral,
// updates radiance and transmittance, and holds the result register.
// ----------------------------------------------------------------------------
module vsi_back import vsi_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  vsi_item_t        q_item,
    input  vsi_qstat_t       qstat,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0][31:0] out_radiance,
    output logic [16:0]      out_trans
);

    back_state_t state_reg, state_next;

    logic [2:0][31:0] rad_reg;
    logic [16:0]      trans_reg;
    logic [2:0][31:0] base_reg;
    logic [2:0][31:0] w_reg;
    logic [31:0]      integral_reg;
    logic [16:0]      tnew_reg;
    logic             valid_reg;
    logic [2:0][31:0] ores_reg;
    logic [16:0]      otrans_reg;

    logic [16:0]      old_t;
    logic [33:0]      t_prod;
    logic             fire;
    logic [2:0][31:0] acc_next;

    assign old_t     = q_item.first ? ONE_Q16 : trans_reg;
    assign t_prod    = 34'(old_t) * 34'(q_item.t16) + 34'd32768;
    assign q_pop     = (state_reg == B_IDLE) && !qstat.empty;
    assign fire      = (state_reg == B_ACC) && (!valid_reg || out_ready);
    assign out_valid    = valid_reg;
    assign out_radiance = ores_reg;
    assign out_trans    = otrans_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [48:0] s;
            s = 49'(base_reg[c]) + 49'((64'(w_reg[c]) * 64'(integral_reg)) >> 16);
            acc_next[c] = (s > 49'(MAX32)) ? MAX32 : s[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
            rad_reg   <= '0;
            trans_reg <= ONE_Q16;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                valid_reg <= 1'b1;
                rad_reg   <= acc_next;
                trans_reg <= tnew_reg;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!qstat.empty) state_next = B_ACC;
            B_ACC:   if (fire) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            for (int c = 0; c < 3; c++) begin
                w_reg[c]    <= 32'((49'(q_item.src[c]) * 49'(old_t)) >> 16);
                base_reg[c] <= q_item.first ? 32'd0 : rad_reg[c];
            end
            integral_reg <= q_item.integral;
            tnew_reg     <= t_prod[32:16];
        end
        if (fire) begin
            ores_reg   <= acc_next;
            otrans_reg <= tnew_reg;
        end
    end

endmodule

// ===== rtl/vsi_checker.sv =====
// ----------------------------------------------------------------------------
// vsi_checker
// Port-level checks on the integrator, bound to the top level.
// ----------------------------------------------------------------------------
module vsi_checker import vsi_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_trans_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[112:96] <= ONE_Q16)
        else $error("transmittance above one");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while slice in progress");

endmodule

bind volumetric_scatter_integrate_unit vsi_checker u_vsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_volumetric_scatter_integrate_unit.sv =====
// ----------------------------------------------------------------------------
// tb_volumetric_scatter_integrate_unit
// Streams froxel column slices through the integrator and checks every
// result beat against a bit-exact scoreboard model of the column accumulation
// or against the values given with a directed slice. The run goes through
// several light settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_volumetric_scatter_integrate_unit;
    import vsi_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_ITEMS    = 175;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    typedef struct {
        bit          first;
        bit [23:0]   ext;
        bit [23:0]   scat [3];
        bit [23:0]   emit [3];
        bit [16:0]   vis;
        bit [31:0]   step;
    } slice_t;

    typedef struct {
        bit [31:0] rad [3];
        bit [16:0] trans;
    } column_out_t;

    typedef struct {
        slice_t      s;
        bit          typed;
        column_out_t res;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    volumetric_scatter_integrate_unit u_dut (.*);

    always #2 aclk = ~aclk;

    bit [63:0]   exp2_tab [EXP_TABLE_SIZE];
    bit [63:0]   light [3];
    bit [63:0]   rad_sum [3];
    bit [63:0]   trans_acc;
    column_out_t expected_q [$];
    idle_mode_t  mode = IDLE_NONE;
    int          errors = 0;
    int          quiet_cycles = 0;

    function automatic void fill_exp2_tab();
        bit [63:0] y, acc, term;
        for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
            y = (64'(i) * 64'd2977044472) >> EXP_TABLE_BITS;
            acc = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int n = 1; n <= 24; n++) begin
                term = ((term * y) >> 32) / 64'(n);
                if (n % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
            exp2_tab[i] = acc;
        end
    endfunction

    function automatic bit [63:0] slice_transmit_q32(bit [63:0] od);
        bit [63:0] z, k, frac, idx, r, a, b, v;
        if (od >= (64'd16 << 32)) return 0;
        z = od * 64'd1512775;
        k = z >> 52;
        frac = z & ((64'd1 << 52) - 1);
        idx = frac >> (52 - EXP_TABLE_BITS);
        r = (frac >> (36 - EXP_TABLE_BITS)) & 64'hFFFF;
        a = exp2_tab[idx];
        b = exp2_tab[idx + 1];
        v = a - (((a - b) * r) >> 16);
        return v >> k;
    endfunction

    function automatic column_out_t integrate_slice(slice_t s);
        column_out_t o;
        bit [63:0] vis, tq, t16, integral, old_t, src, w;
        vis = (s.vis > 17'd65536) ? 64'd65536 : 64'(s.vis);
        if (s.first) begin
            rad_sum = '{0, 0, 0};
            trans_acc = 65536;
        end
        tq = slice_transmit_q32(64'(s.ext) * 64'(s.step));
        t16 = (tq + 32768) >> 16;
        if (s.ext == 0) begin
            integral = s.step;
        end else begin
            integral = ((64'd1 << 32) - tq) / 64'(s.ext);
            if (integral > s.step) integral = s.step;
        end
        old_t = trans_acc;
        for (int c = 0; c < 3; c++) begin
            src = ((((64'(s.scat[c]) * light[c]) >> 16) * vis) >> 16) + s.emit[c];
            if (src > 64'hFFFF_FFFF) src = 64'hFFFF_FFFF;
            w = (src * old_t) >> 16;
            rad_sum[c] = rad_sum[c] + ((w * integral) >> 16);
            if (rad_sum[c] > 64'hFFFF_FFFF) rad_sum[c] = 64'hFFFF_FFFF;
            o.rad[c] = rad_sum[c][31:0];
        end
        trans_acc = (old_t * t16 + 32768) >> 16;
        o.trans = trans_acc[16:0];
        return o;
    endfunction

    function automatic bit [31:0] rand_bits(int w);
        int n;
        bit [63:0] v;
        n = $urandom_range(0, w);
        v = {$urandom, $urandom};
        return 32'(v & ((64'd1 << n) - 1));
    endfunction

    function automatic slice_t rand_slice(bit first);
        slice_t s;
        s.first = first;
        s.ext = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'(rand_bits(24));
        for (int c = 0; c < 3; c++) begin
            s.scat[c] = 24'(rand_bits(24));
            s.emit[c] = 24'(rand_bits(24));
        end
        s.vis = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        s.step = rand_bits(32);
        return s;
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_lights(bit [23:0] r, bit [23:0] g, bit [23:0] b);
        logic [CFG_ADDR_W-1:0] addrs [4];
        bit [23:0] vals [4];
        addrs = '{REG_LIGHT_RED, REG_LIGHT_GREEN, REG_LIGHT_BLUE, REG_UNUSED};
        vals = '{r, g, b, 24'($urandom)};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= addrs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        light = '{r, g, b};
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        wait_cycles(DRAIN_CYCLES);
    endtask

    // hold valid high across back-to-back beats; drop it only for a gap
    task automatic send_slice(slice_t s, bit typed, column_out_t res);
        column_out_t p;
        int          pct;
        pct = (mode == IDLE_SEND) ? 65 : ((mode == IDLE_BOTH) ? 19 : 0);
        while ($urandom_range(0, 99) < pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= s.first;
        s_tdata <= {7'd0, s.step, s.vis, s.emit[2], s.emit[1], s.emit[0],
                    s.scat[2], s.scat[1], s.scat[0], s.ext};
        do @(posedge aclk); while (!s_tready);
        p = integrate_slice(s);
        expected_q.push_back(typed ? res : p);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    column_out_t e;
                    e = expected_q.pop_front();
                    if (m_tdata[31:0] !== e.rad[0]) begin
                        $error("radiance_red exp %h got %h", e.rad[0], m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== e.rad[1]) begin
                        $error("radiance_green exp %h got %h", e.rad[1], m_tdata[63:32]);
                        errors++;
                    end
                    if (m_tdata[95:64] !== e.rad[2]) begin
                        $error("radiance_blue exp %h got %h", e.rad[2], m_tdata[95:64]);
                        errors++;
                    end
                    if (m_tdata[112:96] !== e.trans) begin
                        $error("transmittance exp %h got %h", e.trans, m_tdata[112:96]);
                        errors++;
                    end
                end
            end
            case (mode)
                IDLE_RECV: m_tready <= ($urandom_range(0, 99) >= 65);
                IDLE_BOTH: m_tready <= ($urandom_range(0, 99) >= 19);
                default:   m_tready <= 1'b1;
            endcase
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_volumetric_scatter_integrate_unit NOT OK");
                $finish;
            end
        end
    end

    function automatic dir_row_t mk_row(bit first, bit [23:0] ext, bit [23:0] scat,
                                        bit [23:0] emit, bit [16:0] vis, bit [31:0] step,
                                        bit typed, bit [31:0] rad, bit [16:0] trans);
        dir_row_t d;
        d.s.first = first;
        d.s.ext = ext;
        d.s.scat = '{scat, scat, scat};
        d.s.emit = '{emit, emit, emit};
        d.s.vis = vis;
        d.s.step = step;
        d.typed = typed;
        d.res.rad = '{rad, rad, rad};
        d.res.trans = trans;
        return d;
    endfunction

    initial begin
        dir_row_t    rows [$];
        int          col_left;
        bit          first;
        column_out_t none;
        none = '{'{0, 0, 0}, 0};
        fill_exp2_tab();
        light = '{0, 0, 0};
        rad_sum = '{0, 0, 0};
        trans_acc = 65536;
        wait_cycles(4);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_lights(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);

        rows.push_back(mk_row(1, 0, 0, 0, 0, 0, 1, 0, 17'd65536));
        rows.push_back(mk_row(1, 0, 0, 24'hFFFFFF, 17'd65536, 32'h10000,
                              1, 32'hFFFFFF, 17'd65536));
        rows.push_back(mk_row(1, 24'hFFFFFF, 0, 0, 0, 32'hFFFFFFFF, 1, 0, 0));
        rows.push_back(mk_row(1, 0, 0, 24'hFFFFFF, 17'd65536, 32'hFFFFFFFF,
                              1, 32'hFFFFFFFF, 17'd65536));
        rows.push_back(mk_row(0, 24'h010000, 24'hFFFFFF, 24'hFFFFFF, 17'd65536,
                              32'h10000, 0, 0, 0));
        rows.push_back(mk_row(1, 24'h008000, 24'h010000, 24'h000100, 17'h1FFFF,
                              32'h20000, 0, 0, 0));
        rows.push_back(mk_row(0, 24'h008000, 24'h010000, 24'h000100, 17'd65536,
                              32'h20000, 0, 0, 0));
        rows.push_back(mk_row(0, 24'h000001, 24'hFFFFFF, 0, 17'd32768, 32'h1, 0, 0, 0));
        rows.push_back(mk_row(0, 24'h123456, 24'h0ABCDE, 24'h00FFFF, 17'd0, 0, 0, 0, 0));
        rows.push_back(mk_row(0, 24'h000400, 24'hFFFFFF, 24'hFFFFFF, 17'd65535,
                              32'h00400000, 0, 0, 0));
        rows.push_back(mk_row(1, 24'h000010, 24'h800000, 24'h000001, 17'd1,
                              32'h80000000, 0, 0, 0));
        rows.push_back(mk_row(0, 24'h0FFFFF, 24'h7FFFFF, 24'h7FFFFF, 17'd65537,
                              32'h00001000, 0, 0, 0));
        foreach (rows[i]) send_slice(rows[i].s, rows[i].typed, rows[i].res);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: write_lights(24'($urandom), 24'($urandom), 24'($urandom));
                1: write_lights(0, 0, 0);
                2: write_lights(24'(rand_bits(18)), 24'(rand_bits(18)), 24'(rand_bits(18)));
                default: write_lights(24'($urandom), 24'hFFFFFF, 24'(rand_bits(24)));
            endcase
            mode = idle_mode_t'(ph);
            col_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    while (expected_q.size() != 0) @(posedge aclk);
                end
                if (col_left == 0) begin
                    col_left = $urandom_range(1, 16);
                    first = ($urandom_range(0, 19) != 0);
                end else begin
                    first = ($urandom_range(0, 19) == 0);
                end
                col_left--;
                send_slice(rand_slice(first), 0, none);
            end
            s_tvalid <= 1'b0;
        end

        mode = IDLE_NONE;
        drain();
        if (errors == 0) begin
            $display("tb_volumetric_scatter_integrate_unit OK");
        end else begin
            $display("tb_volumetric_scatter_integrate_unit NOT OK");
        end
        $finish;
    end

endmodule
